// ----- rtl/core/set_assoc_lru_cache_tags_core_macros.svh -----
// Assertion macros shared by the cache tag store RTL.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SALRU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SALRU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/salru_pkg.sv -----
// Shared constants and types of the set-associative LRU tag store.
package salru_pkg;

    localparam int LINE_SIZE  = 64;
    localparam int SET_COUNT  = 4;
    localparam int WAY_COUNT  = 2;
    localparam int ADDR_BITS  = 32;
    localparam int STAMP_BITS = 32;

    localparam int OFFSET_BITS  = $clog2(LINE_SIZE);
    localparam int SET_BITS     = $clog2(SET_COUNT);
    localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - SET_BITS;
    localparam int WAY_IDX_BITS = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
    } way_t;

    typedef way_t [WAY_COUNT-1:0] row_t;

    localparam int ROW_BITS = $bits(row_t);

    typedef struct packed {
        logic                    hit;
        logic [WAY_IDX_BITS-1:0] hit_way;
        logic [WAY_IDX_BITS-1:0] victim;
    } match_t;

endpackage

// ----- rtl/core/salru_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/salru_match.sv -----
// Way compare and LRU victim pick over one set row.
module salru_match (
    input  salru_pkg::row_t                    row,
    input  logic [salru_pkg::TAG_BITS-1:0]     tag,
    output salru_pkg::match_t                  result
);

    logic [salru_pkg::STAMP_BITS-1:0] min_stamp;

    always_comb
    begin
        result.hit     = 1'b0;
        result.hit_way = '0;
        // walk down so the lowest matching way wins
        for (int w = salru_pkg::WAY_COUNT - 1; w >= 0; w--)
        begin
            if (row[w].valid && (row[w].tag == tag))
            begin
                result.hit     = 1'b1;
                result.hit_way = salru_pkg::WAY_IDX_BITS'(w);
            end
        end

        min_stamp     = row[0].stamp;
        result.victim = '0;
        // strict less-than keeps the lowest way on ties
        for (int w = 1; w < salru_pkg::WAY_COUNT; w++)
        begin
            if (row[w].stamp < min_stamp)
            begin
                min_stamp     = row[w].stamp;
                result.victim = salru_pkg::WAY_IDX_BITS'(w);
            end
        end
    end

endmodule

// ----- rtl/core/set_assoc_lru_cache_tags_core.sv -----
// Top level of the set-associative tag store with true LRU replacement.
//
// Usage:
//   Command channel: drive opcode and byte_address with start high; the
//   beat is taken at a clock edge where busy is low. opcode OP_ACCESS looks
//   up the address, OP_CLEAR invalidates every line and zeroes the stamp.
//   Result channel: done pulses for exactly one cycle with hit valid in the
//   same cycle. The receiver cannot stall, so every result must be sampled
//   on the cycle that done is high.
//   Order: the accepting edge enters the compare state, and done is
//   registered as that state ends.
//   Flow: the set row lives in a tag RAM with registered read data; the
//   accepting edge reads the row, the next cycle compares all ways in
//   parallel, picks the victim and writes the row back. busy is high during
//   that compare cycle, so no two accesses overlap on the same row and no
//   forwarding is needed.
//   A new beat may be taken in the cycle where the previous result shows.
//   Reset: rst_n clears the control state, the access stamp and one valid
//   flop per set row; a row whose flop is clear reads as all zero, so
//   clear-all drops every row through those flops and no RAM sweep is needed.
module set_assoc_lru_cache_tags_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            opcode,
    input  logic [salru_pkg::ADDR_BITS-1:0] byte_address,
    output logic                            done,
    output logic                            hit
);

    `include "set_assoc_lru_cache_tags_core_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    logic                                 state_reg, state_next;
    logic                                 op_reg;
    logic [salru_pkg::SET_IDX_BITS-1:0]   set_reg;
    logic [salru_pkg::TAG_BITS-1:0]       tag_reg;
    logic [salru_pkg::SET_COUNT-1:0]      row_valid_reg, row_valid_next;
    logic [salru_pkg::STAMP_BITS-1:0]     count_reg, count_next;
    logic                                 done_reg, done_next;
    logic                                 hit_reg, hit_next;

    logic                                 accept;
    logic [salru_pkg::SET_IDX_BITS-1:0]   in_set;
    logic [salru_pkg::TAG_BITS-1:0]       in_tag;
    logic                                 ram_re;
    logic                                 ram_we;
    logic [salru_pkg::ROW_BITS-1:0]       ram_rdata;
    salru_pkg::row_t                      row_eff;
    salru_pkg::row_t                      row_wr;
    salru_pkg::match_t                    match;
    logic [salru_pkg::WAY_IDX_BITS-1:0]   sel_way;
    logic [salru_pkg::STAMP_BITS-1:0]     stamp_inc;

    assign busy   = (state_reg == ST_LOOK);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign hit    = hit_reg;

    // split the byte address: offset | set | tag
    assign in_set = (salru_pkg::SET_COUNT > 1)
                  ? byte_address[salru_pkg::OFFSET_BITS +: salru_pkg::SET_IDX_BITS]
                  : '0;
    assign in_tag = byte_address[salru_pkg::ADDR_BITS-1 -: salru_pkg::TAG_BITS];

    // read the set row on the accepting edge; clear needs no read
    assign ram_re = accept && (opcode == salru_pkg::OP_ACCESS);

    salru_ram #(
        .WIDTH (salru_pkg::ROW_BITS),
        .DEPTH (salru_pkg::SET_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (ram_re),
        .raddr (in_set),
        .rdata (ram_rdata)
    );

    // a row never written since the last clear reads as all zero
    assign row_eff = row_valid_reg[set_reg] ? salru_pkg::row_t'(ram_rdata) : '0;

    salru_match u_match (
        .row    (row_eff),
        .tag    (tag_reg),
        .result (match)
    );

    assign stamp_inc = count_reg + 1'b1;
    assign sel_way   = match.hit ? match.hit_way : match.victim;

    // refresh the hit way, or fill the victim; the stamp wraps at its width
    always_comb
    begin
        row_wr                = row_eff;
        row_wr[sel_way].valid = 1'b1;
        row_wr[sel_way].tag   = tag_reg;
        row_wr[sel_way].stamp = stamp_inc;
    end

    assign ram_we = (state_reg == ST_LOOK) && (op_reg == salru_pkg::OP_ACCESS);

    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        hit_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (op_reg == salru_pkg::OP_CLEAR)
                begin
                    // drop every row and restart the stamp
                    row_valid_next = '0;
                    count_next     = '0;
                end
                else
                begin
                    row_valid_next[set_reg] = 1'b1;
                    count_next              = stamp_inc;
                    hit_next                = match.hit;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            hit_reg       <= hit_next;
        end
    end

    // hold the command beat for the compare cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            set_reg <= in_set;
            tag_reg <= in_tag;
        end
    end

    `SALRU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "beat taken but block not busy")
    `SALRU_ASSERT_NEXT(a_look_once, busy, !busy && done, "compare cycle did not end in a result")
    `SALRU_ASSERT_IMPLY(a_done_idle, done, !busy, "result shown while still busy")
    `SALRU_ASSERT_NEXT(a_clear_miss, busy && (op_reg == salru_pkg::OP_CLEAR), !hit,
                       "clear reported a hit")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the set-associative LRU cache tag store.
module tb_top;
    import salru_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BEATS = 750;
    localparam int POOL_DEPTH   = 6;
    localparam int MAX_SHOWN    = 10;

    // One command beat waiting for the driver: idle cycles ahead of it and an
    // optional hold until every outstanding result has come back.
    typedef struct {
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        int unsigned          gap;
        bit                   drain;
    } access_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 opcode = OP_ACCESS;
    logic [ADDR_BITS-1:0] byte_address = '0;
    logic                 busy;
    logic                 done;
    logic                 hit;

    access_beat_t  access_q[$];
    logic          expected_hit_q[$];
    bit            beat_taken = 1'b0;
    int unsigned   idle_left = 0;
    int unsigned   fail_count = 0;

    // Shadow copy of the tag store.
    logic                  line_ok   [SET_COUNT][WAY_COUNT];
    logic [TAG_BITS-1:0]   line_tags [SET_COUNT][WAY_COUNT];
    logic [STAMP_BITS-1:0] way_stamp [SET_COUNT][WAY_COUNT];
    logic [STAMP_BITS-1:0] stamp_now;

    // Small tag pool so that random lookups keep hitting and evicting.
    logic [TAG_BITS-1:0] tag_pool [POOL_DEPTH];
    int unsigned         pool_size = 2;

    always #2 clk = ~clk;

    set_assoc_lru_cache_tags_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .byte_address (byte_address),
        .done         (done),
        .hit          (hit)
    );

    // Advance the shadow store by one command and return the hit flag it yields.
    // A clear empties every way and zeroes the access stamp; a lookup bumps the
    // stamp, refreshes a matching way, or else fills the way with the smallest
    // stamp (lowest way on ties, so empty ways go first).
    function automatic logic predict_hit(logic op, logic [ADDR_BITS-1:0] addr);
        logic [ADDR_BITS-1:0] line_no;
        int unsigned          set_idx;
        logic [TAG_BITS-1:0]  tag_val;
        int unsigned          victim;
        if (op == OP_CLEAR) begin
            for (int s = 0; s < SET_COUNT; s++) begin
                for (int w = 0; w < WAY_COUNT; w++) begin
                    line_ok[s][w]   = 1'b0;
                    line_tags[s][w] = '0;
                    way_stamp[s][w] = '0;
                end
            end
            stamp_now = '0;
            return 1'b0;
        end
        line_no   = addr / LINE_SIZE;
        set_idx   = line_no % SET_COUNT;
        tag_val   = line_no / SET_COUNT;
        stamp_now = stamp_now + 1'b1;
        for (int w = 0; w < WAY_COUNT; w++) begin
            if (line_ok[set_idx][w] && line_tags[set_idx][w] == tag_val) begin
                way_stamp[set_idx][w] = stamp_now;
                return 1'b1;
            end
        end
        victim = 0;
        for (int w = 1; w < WAY_COUNT; w++) begin
            if (way_stamp[set_idx][w] < way_stamp[set_idx][victim])
                victim = w;
        end
        line_ok[set_idx][victim]   = 1'b1;
        line_tags[set_idx][victim] = tag_val;
        way_stamp[set_idx][victim] = stamp_now;
        return 1'b0;
    endfunction

    task automatic queue_access(logic op, logic [ADDR_BITS-1:0] addr,
                                int unsigned gap, bit drain);
        access_beat_t b;
        b.op    = op;
        b.addr  = addr;
        b.gap   = gap;
        b.drain = drain;
        access_q.push_back(b);
    endtask

    // Mostly pool tags with random set and offset; now and then a fully random
    // address so that every address bit toggles.
    function automatic logic [ADDR_BITS-1:0] pick_address();
        logic [ADDR_BITS-1:0] a;
        a = $urandom;
        if ($urandom_range(0, 9) != 0)
            a[ADDR_BITS-1:OFFSET_BITS+SET_BITS] = tag_pool[$urandom_range(0, pool_size-1)];
        return a;
    endfunction

    task automatic note_failure(string what);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("ERROR: %s", what);
    endtask

    // Driver: present a beat at the falling edge and hold it while busy keeps
    // it out. Insert the idle cycles of each burst gap, and stall a beat marked
    // for drain until every expected result is in.
    always @(negedge clk) begin
        access_beat_t head;
        if (rst_n) begin
            if (start && !beat_taken) begin
                // hold: the last rising edge did not take this beat
            end else if (idle_left != 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (access_q.size() != 0 && access_q[0].gap != 0) begin
                start          <= 1'b0;
                idle_left      <= access_q[0].gap - 1;
                access_q[0].gap = 0;
            end else if (access_q.size() != 0 &&
                         (!access_q[0].drain || expected_hit_q.size() == 0)) begin
                head          = access_q.pop_front();
                start        <= 1'b1;
                opcode       <= head.op;
                byte_address <= head.addr;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: at each rising edge check a result shown this cycle against the
    // oldest prediction, then predict the beat taken at this same edge. The
    // result of a beat never shows at the edge that takes it.
    always @(posedge clk) begin
        logic want;
        if (rst_n) begin
            beat_taken <= start && !busy;
            if (done) begin
                if (expected_hit_q.size() == 0) begin
                    note_failure($sformatf("result hit=%b with no beat outstanding", hit));
                end else begin
                    want = expected_hit_q.pop_front();
                    if (hit !== want)
                        note_failure($sformatf("hit expected %b, got %b", want, hit));
                end
            end
            if (start && !busy)
                expected_hit_q.push_back(predict_hit(opcode, byte_address));
        end
    end

    // Watchdog.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int unsigned burst_left;
        int unsigned gap;
        logic        op;

        void'(predict_hit(OP_CLEAR, '0));

        // Directed beats: line reuse, set spread, LRU eviction order, address
        // extremes, clear with stray address bits, back-to-back clears.
        queue_access(OP_ACCESS, 32'h0000_0000, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_003F, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0040, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0100, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0000, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0200, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0100, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0200, 0, 1'b0);
        queue_access(OP_ACCESS, 32'hFFFF_FFFF, 0, 1'b0);
        queue_access(OP_ACCESS, 32'hFFFF_FFC0, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_00C0, 0, 1'b0);
        queue_access(OP_ACCESS, 32'hFFFF_FF80, 0, 1'b0);
        queue_access(OP_CLEAR,  32'hFFFF_FFFF, 0, 1'b0);
        queue_access(OP_ACCESS, 32'hFFFF_FFFF, 0, 1'b0);
        queue_access(OP_CLEAR,  32'h0000_0000, 0, 1'b0);
        queue_access(OP_CLEAR,  32'h5A5A_5A5A, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0000, 0, 1'b1);
        queue_access(OP_ACCESS, 32'h0000_0000, 0, 1'b0);
        queue_access(OP_ACCESS, 32'hAAAA_AAAA, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h5555_5555, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h8000_0000, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h7FFF_FFFF, 0, 1'b0);
        queue_access(OP_ACCESS, 32'h0000_0000, 3, 1'b1);

        // Random beats in bursts; reshuffle the tag pool now and then so the
        // working set grows and shrinks around the way count.
        burst_left = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) begin
                pool_size = $urandom_range(2, POOL_DEPTH);
                for (int i = 0; i < POOL_DEPTH; i++) begin
                    case ($urandom_range(0, 7))
                        0:       tag_pool[i] = '0;
                        1:       tag_pool[i] = '1;
                        default: tag_pool[i] = $urandom;
                    endcase
                end
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            end else begin
                gap = 0;
            end
            burst_left--;
            op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_ACCESS;
            queue_access(op, pick_address(), gap, n % 150 == 75);
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Drain: every beat taken and every result back, then a wait to catch a
        // stray strobe.
        while (access_q.size() != 0 || start || expected_hit_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/salru_pkg.sv
rtl/core/salru_ram.sv
rtl/core/salru_match.sv
rtl/core/set_assoc_lru_cache_tags_core.sv
tb/tb_top.sv
